@@ design/npc_pkg.sv @@
// npc_pkg: shared types, constants and widths of the nearest palette color search.
// No dependencies; imported by every module of the block but npc_fifo.
`default_nettype none

package npc_pkg;

  localparam int DEFAULT_DEPTH = 256;   // palette entries
  localparam int COLOR_W       = 8;     // bits per channel
  localparam int IDX_W         = 8;     // entry_index / best_index width
  localparam int CFG_W         = 9;     // entries_in_use width
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
  // Max distance is 3*255*255 = 195075, below 2**18; an all-ones start value
  // is larger than any real distance, like the nominal 0x7FFFFFFF start.
  localparam int DIST_W        = 18;
  localparam int SQ_W          = 2 * COLOR_W;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Classified item as it waits between front and back
  typedef struct packed {
    logic               is_query;
    logic               wr_ok;     // write index lands inside the palette
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } cmd_t;

  // Head of the command queue seen by the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  // Back status toward the top level
  typedef struct packed {
    logic busy;      // scanning a query
    logic take;      // command queue head consumed this cycle
  } bk_status_t;

endpackage

`default_nettype wire

@@ design/npc_fifo.sv @@
// npc_fifo: two-entry first-in first-out queue with full/empty flags.
// Depends on nothing; used by npc_front and npc_back.
`default_nettype none

module npc_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  logic [WIDTH-1:0] store_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) store_r[wp_r] <= din;
  end

endmodule

`default_nettype wire

@@ design/npc_front.sv @@
// npc_front: accepts input items, classifies them and queues them for the back.
// Depends on npc_pkg and npc_fifo.
`default_nettype none

module npc_front
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_command,
  input  wire logic [IDX_W-1:0]   in_entry_index,
  input  wire logic [COLOR_W-1:0] in_red,
  input  wire logic [COLOR_W-1:0] in_green,
  input  wire logic [COLOR_W-1:0] in_blue,
  output cmd_head_t               head,
  input  wire logic               head_pop
);

  cmd_t cmd_in, cmd_out;
  logic q_empty;

  // classify: query vs write, and flag writes beyond the palette
  always_comb begin
    cmd_in.is_query = (in_command == CMD_QUERY);
    cmd_in.wr_ok    = (32'(in_entry_index) < 32'(PALETTE_DEPTH));
    cmd_in.idx      = in_entry_index;
    cmd_in.red      = in_red;
    cmd_in.green    = in_green;
    cmd_in.blue     = in_blue;
  end

  npc_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (head_pop),
    .dout  (cmd_out),
    .empty (q_empty)
  );

  assign head.valid = !q_empty;
  assign head.cmd   = cmd_out;

endmodule

`default_nettype wire

@@ design/npc_back.sv @@
// npc_back: palette memory, scan sequencer, distance pipeline and result queue.
// Depends on npc_pkg and npc_fifo.
`default_nettype none

module npc_back
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CFG_W-1:0] count_cfg,
  input  cmd_head_t             head,
  output logic                  head_pop,
  output bk_status_t            status,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic [IDX_W-1:0]      out_best_index
);

  localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int ENT_W = 3 * COLOR_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r, state_nxt;

  // palette memory
  logic [ENT_W-1:0] mem [PALETTE_DEPTH];
  logic [ENT_W-1:0] mem_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa;

  // scan control
  logic [AW-1:0]      addr_r;
  logic               issue_r;
  logic [COLOR_W-1:0] q_red_r, q_green_r, q_blue_r;
  logic [CNT_W-1:0]   cnt_sat;

  // pipeline: read data stage, square stage
  logic               p1_v_r, p1_last_r;
  logic [AW-1:0]      p1_idx_r;
  logic               p2_v_r, p2_last_r;
  logic [AW-1:0]      p2_idx_r;
  logic [SQ_W-1:0]    sq_r_r, sq_g_r, sq_b_r;
  logic [COLOR_W-1:0] d_r, d_g, d_b;

  // running best
  logic [DIST_W-1:0] min_sq_r, sum_sq;
  logic [AW-1:0]     best_idx_r, win_idx;
  logic              better;

  // result queue
  logic             res_push, res_full, take, start_scan, empty_query;
  logic [IDX_W-1:0] res_data;

  // saturate the configured count to the palette depth
  always_comb begin
    if (32'(count_cfg) > 32'(PALETTE_DEPTH)) cnt_sat = CNT_W'(PALETTE_DEPTH);
    else                                     cnt_sat = CNT_W'(count_cfg);
  end

  // take the queue head when idle; a query needs room for its result
  assign take        = (state_r == ST_IDLE) && head.valid &&
                       (!head.cmd.is_query || !res_full);
  assign head_pop    = take;
  assign start_scan  = take && head.cmd.is_query && (cnt_sat != '0);
  assign empty_query = take && head.cmd.is_query && (cnt_sat == '0);

  assign mem_we = take && !head.cmd.is_query && head.cmd.wr_ok;
  assign mem_wa = AW'(head.cmd.idx);
  assign mem_re = (state_r == ST_SCAN) && issue_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= {head.cmd.red, head.cmd.green, head.cmd.blue};
    if (mem_re) mem_q <= mem[addr_r];
  end

  // state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start_scan) state_nxt = ST_SCAN;
      ST_SCAN: if (p2_v_r && p2_last_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      issue_r <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start_scan)                 issue_r <= 1'b1;
      else if (mem_re && addr_r == '0) issue_r <= 1'b0;
      p1_v_r <= mem_re;
      p2_v_r <= p1_v_r;
    end
  end

  // address countdown, query color, pipeline tags
  always_ff @(posedge clk) begin
    if (start_scan) begin
      addr_r    <= AW'(cnt_sat - CNT_W'(1));
      q_red_r   <= head.cmd.red;
      q_green_r <= head.cmd.green;
      q_blue_r  <= head.cmd.blue;
    end else if (mem_re) begin
      addr_r <= addr_r - AW'(1);
    end
    p1_last_r <= (addr_r == '0);
    p1_idx_r  <= addr_r;
    p2_last_r <= p1_last_r;
    p2_idx_r  <= p1_idx_r;
    sq_r_r    <= SQ_W'(d_r) * SQ_W'(d_r);
    sq_g_r    <= SQ_W'(d_g) * SQ_W'(d_g);
    sq_b_r    <= SQ_W'(d_b) * SQ_W'(d_b);
  end

  // absolute channel differences
  always_comb begin
    logic [COLOR_W-1:0] m_r, m_g, m_b;
    {m_r, m_g, m_b} = mem_q;
    d_r = (q_red_r   > m_r) ? (q_red_r   - m_r) : (m_r - q_red_r);
    d_g = (q_green_r > m_g) ? (q_green_r - m_g) : (m_g - q_green_r);
    d_b = (q_blue_r  > m_b) ? (q_blue_r  - m_b) : (m_b - q_blue_r);
  end

  // sum and compare; strictly smaller wins, so ties keep the higher index
  assign sum_sq  = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);
  assign better  = p2_v_r && (sum_sq < min_sq_r);
  assign win_idx = better ? p2_idx_r : best_idx_r;

  always_ff @(posedge clk) begin
    if (start_scan) begin
      min_sq_r   <= '1;
      best_idx_r <= '0;
    end else if (better) begin
      min_sq_r   <= sum_sq;
      best_idx_r <= p2_idx_r;
    end
  end

  // result: empty search gives index 0, otherwise low bits of the winner
  assign res_push = empty_query || (p2_v_r && p2_last_r);
  assign res_data = empty_query ? IDX_W'(0) : IDX_W'(win_idx);

  npc_fifo #(.WIDTH(IDX_W)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_best_index),
    .empty (out_empty)
  );

  assign status.busy = (state_r == ST_SCAN);
  assign status.take = take;

endmodule

`default_nettype wire

@@ design/nearest_palette_color_search.sv @@
// nearest_palette_color_search: top level; config register, front and back.
// Depends on npc_pkg, npc_front, npc_back (and npc_fifo through them).
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_push / in_full  | in_command, in_entry_index, in_red/green/blue
//  out     | out_pop / out_empty| out_best_index
//  cfg     | cfg_we             | cfg_wdata (entries_in_use)
//
// The back writes a write item to the palette in the cycle it takes it. The time a
// query takes from reaching the head of the command queue to its result is
// set by the one-entry-per-cycle read of the palette memory plus the
// read and square pipeline stages; an empty search is answered in the cycle it is taken.
// Synchronous reset empties both queues and sets entries_in_use to 256; the
// palette is not cleared. A two-entry queue on each side lets the input keep
// accepting while the back scans or a result waits to be popped.
`default_nettype none

module nearest_palette_color_search
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_command,
  input  wire logic [IDX_W-1:0]   in_entry_index,
  input  wire logic [COLOR_W-1:0] in_red,
  input  wire logic [COLOR_W-1:0] in_green,
  input  wire logic [COLOR_W-1:0] in_blue,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [IDX_W-1:0]        out_best_index,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  logic [CFG_W-1:0] entries_in_use_r;
  cmd_head_t        head;
  logic             head_pop;
  bk_status_t       bk_status;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)      entries_in_use_r <= CFG_RESET;
    else if (cfg_we) entries_in_use_r <= cfg_wdata;
  end

  npc_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .head           (head),
    .head_pop       (head_pop)
  );

  npc_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .count_cfg      (entries_in_use_r),
    .head           (head),
    .head_pop       (head_pop),
    .status         (bk_status),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_best_index (out_best_index)
  );

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // the back consumes only a present head
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head.valid)
    else $error("command queue popped while empty");

  // no new command is taken while a scan runs
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.busy |-> !bk_status.take && !head_pop)
    else $error("command taken during scan");

  // a scan starts only from a query at the head
  a_scan_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(bk_status.busy) |-> $past(head.valid && head.cmd.is_query && head_pop))
    else $error("scan started without a query");

endmodule

`default_nettype wire

@@ sim/nearest_palette_color_search_tb.sv @@
// Self-checking testbench for nearest_palette_color_search: queued driver, result monitor,
// in-bench nearest-color predictor and phase sequencer for entries_in_use.
// Depends on npc_pkg and the nearest_palette_color_search RTL.

module nearest_palette_color_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  localparam int DRAIN_CYCLES   = 300;       // longest scan of all 256 entries plus margin
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int STALL_CYCLES   = 2000;      // long receiver hold-off
  localparam int STALL_AT       = 200;       // results seen before the hold-off starts
  localparam int IDLE_PCT       = 22;
  localparam int RANDOM_PHASES  = 20;
  localparam int ITEMS_PER_PHASE = 100;

  // One palette operation as queued for the driver
  typedef struct packed {
    logic               command;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } palette_op_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_push        = 1'b0;
  logic               in_full;
  logic               in_command     = CMD_WRITE;
  logic [IDX_W-1:0]   in_entry_index = '0;
  logic [COLOR_W-1:0] in_red         = '0;
  logic [COLOR_W-1:0] in_green       = '0;
  logic [COLOR_W-1:0] in_blue        = '0;
  logic               out_empty;
  logic               out_pop        = 1'b0;
  logic [IDX_W-1:0]   out_best_index;
  logic               cfg_we         = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata      = '0;

  palette_op_t         pending_ops[$];
  logic [IDX_W-1:0]    expected_best[$];
  logic [3*COLOR_W-1:0] palette_copy[DEFAULT_DEPTH];
  bit                  written[DEFAULT_DEPTH];
  int unsigned         search_span  = DEFAULT_DEPTH;   // entries_in_use, saturated
  int unsigned         error_count  = 0;
  int unsigned         results_seen = 0;
  int unsigned         cycle_count  = 0;
  int unsigned         hold_left    = 0;
  bit                  hold_done    = 1'b0;
  bit                  calm         = 1'b0;             // no idling on either side
  logic [IDX_W-1:0]    want_index;

  nearest_palette_color_search u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_best_index (out_best_index),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned sq_gap(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // Scan from the top down; only a strictly smaller distance replaces the best
  function automatic logic [IDX_W-1:0] nearest_entry(logic [COLOR_W-1:0] r,
                                                     logic [COLOR_W-1:0] g,
                                                     logic [COLOR_W-1:0] b);
    int unsigned      min_sq;
    int unsigned      sum_sq;
    logic [IDX_W-1:0] best;
    min_sq = 32'h7FFF_FFFF;
    best   = '0;
    for (int k = search_span; k > 0; k--) begin
      sum_sq = sq_gap(r, palette_copy[k-1][3*COLOR_W-1:2*COLOR_W])
             + sq_gap(g, palette_copy[k-1][2*COLOR_W-1:COLOR_W])
             + sq_gap(b, palette_copy[k-1][COLOR_W-1:0]);
      if (sum_sq < min_sq) begin
        min_sq = sum_sq;
        best   = IDX_W'(k - 1);
      end
    end
    return best;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      // item taken at this edge: update the palette copy or queue the answer
      if (in_push && !in_full) begin
        if (in_command == CMD_WRITE) begin
          palette_copy[in_entry_index] = {in_red, in_green, in_blue};
        end else begin
          expected_best.push_back(nearest_entry(in_red, in_green, in_blue));
        end
      end
      // present the next item unless one is still waiting on full
      if (!in_push || !in_full) begin
        if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          palette_op_t op;
          op = pending_ops.pop_front();
          in_push        <= 1'b1;
          in_command     <= op.command;
          in_entry_index <= op.index;
          in_red         <= op.red;
          in_green       <= op.green;
          in_blue        <= op.blue;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen <= results_seen + 1;
        if (expected_best.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual best_index %0d",
                   $time, out_best_index);
          error_count <= error_count + 1;
        end else begin
          want_index = expected_best.pop_front();
          if (out_best_index !== want_index) begin
            $display("%0t: best_index mismatch: expected %0d, actual %0d",
                     $time, want_index, out_best_index);
            error_count <= error_count + 1;
          end
        end
      end
      // one long hold-off so the block backs up into in_full
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_pop   <= 1'b0;
      end else if (!hold_done && results_seen >= STALL_AT) begin
        hold_done <= 1'b1;
        hold_left <= STALL_CYCLES;
        out_pop   <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [COLOR_W-1:0] rand_channel();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 8'hFF : 8'h00;
      1:       return COLOR_W'(32 * $urandom_range(7));   // coarse grid, forces ties
      default: return COLOR_W'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] r,
                             input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    pending_ops.push_back('{CMD_WRITE, idx, r, g, b});
    written[idx] = 1'b1;
  endtask

  task automatic queue_query(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                             input logic [COLOR_W-1:0] b);
    pending_ops.push_back('{CMD_QUERY, IDX_W'($urandom_range(255)), r, g, b});
  endtask

  // Block idle: nothing queued, nothing offered, no answer outstanding
  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_push || expected_best.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_entries_in_use(input logic [CFG_W-1:0] value);
    wait_for_drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    // entries above the palette depth saturate
    search_span = (value > DEFAULT_DEPTH) ? DEFAULT_DEPTH : value;
  endtask

  // Every entry a query can reach must hold a written color
  task automatic fill_prefix();
    for (int i = 0; i < search_span; i++) begin
      if (!written[i]) queue_write(IDX_W'(i), rand_channel(), rand_channel(), rand_channel());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty palette: any query answers 0
    set_entries_in_use(9'd0);
    queue_query(8'h00, 8'h00, 8'h00);
    queue_query(8'hFF, 8'hFF, 8'hFF);
    queue_write(8'd0,   8'h00, 8'h00, 8'h00);
    queue_write(8'd1,   8'hFF, 8'hFF, 8'hFF);
    queue_write(8'd2,   8'h00, 8'h00, 8'h00);   // duplicate of entry 0
    queue_write(8'd255, 8'h80, 8'h80, 8'h80);   // top index, outside the search
    queue_write(8'd3,   8'h0A, 8'h00, 8'h00);
    queue_write(8'd4,   8'h00, 8'h0A, 8'h00);

    // three entries: exact hits, ties toward the higher index, far corners
    set_entries_in_use(9'd3);
    queue_query(8'h00, 8'h00, 8'h00);
    queue_query(8'hFF, 8'hFF, 8'hFF);
    queue_query(8'hFF, 8'h00, 8'h00);
    queue_query(8'h64, 8'h64, 8'h64);
    queue_query(8'h80, 8'h80, 8'h80);
    queue_query(8'h7F, 8'h7F, 8'h7F);

    // equidistant distinct colors at entries 3 and 4
    set_entries_in_use(9'd5);
    queue_query(8'h05, 8'h05, 8'h00);
    queue_query(8'h00, 8'h00, 8'hFF);
    queue_query(8'h0A, 8'h00, 8'h00);

    // random phases across several register settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       count = 9'd1;
        3:       count = 9'd256;
        8:       count = 9'd511;
        11:      count = 9'd0;
        15:      count = CFG_W'(257 + $urandom_range(254));
        default: count = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(17, 64))
                                                  : CFG_W'($urandom_range(1, 16));
      endcase
      calm = (ph == 6);
      set_entries_in_use(count);
      fill_prefix();
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(1)) begin
          queue_query(rand_channel(), rand_channel(), rand_channel());
        end else if (search_span != 0 && $urandom_range(3) != 0) begin
          queue_write(IDX_W'($urandom_range(search_span - 1)),
                      rand_channel(), rand_channel(), rand_channel());
        end else begin
          queue_write(IDX_W'($urandom_range(255)),
                      rand_channel(), rand_channel(), rand_channel());
        end
      end
    end
    calm = 1'b0;

    wait_for_drain();
    if (error_count == 0 && expected_best.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
